/* hw/rtl/lsh_pkg.sv */
// Shared types, codes and constants for the link setup handshake.
package lsh_pkg;

	localparam int unsigned TICK_W     = 16;
	localparam int unsigned RETRY_W    = 4;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned FRAME_LEN  = 5;
	localparam int unsigned FIDX_W     = $clog2(FRAME_LEN);

	localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = 16'd3;
	localparam logic [RETRY_W-1:0] MAX_TIMEOUTS_RST  = 4'd3;
	localparam logic [RETRY_W-1:0] RETRY_SAT         = 4'd15;

	localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h5c;
	localparam logic [BYTE_W-1:0] ADDR_TX   = 8'h01;
	localparam logic [BYTE_W-1:0] ADDR_RX   = 8'h03;
	localparam logic [BYTE_W-1:0] CTRL_SET  = 8'h03;
	localparam logic [BYTE_W-1:0] CTRL_UA   = 8'h07;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_RX    = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_UP   = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUTS  = 1'd1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_UP   = 2'd2,
		PH_FAIL = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		FS_FLAG = 3'd0,
		FS_ADDR = 3'd1,
		FS_CTRL = 3'd2,
		FS_BCC  = 3'd3,
		FS_END  = 3'd4
	} frame_state_t;

	typedef enum logic [1:0] {
		BURST_NONE = 2'd0,
		BURST_SET  = 2'd1,
		BURST_UP   = 2'd2,
		BURST_FAIL = 2'd3
	} burst_t;

	typedef struct packed {
		logic   valid;
		burst_t kind;
	} burst_req_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] tx_byte;
		logic              last;
	} out_item_t;

	function automatic logic [BYTE_W-1:0] set_byte(input logic [FIDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		case (idx)
			3'd0:    b = FLAG_BYTE;
			3'd1:    b = ADDR_TX;
			3'd2:    b = CTRL_SET;
			3'd3:    b = ADDR_TX ^ CTRL_SET;
			default: b = FLAG_BYTE;
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/link_setup_handshake.sv */
// Top level of the link setup handshake: input register, config registers, control, results.
// An accepted item waits in the input register; its results are then registered in the result register.
// Throughput: one item per cycle; an item that causes results waits in the input register
// until the final result of the previous burst is taken.
// Reset: phase idle, recognizer at start flag, counters zero, timeout_ticks 3,
// max_timeouts 3, no result pending.
module link_setup_handshake import lsh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic               valid_s1;
	in_item_t           item_s1;
	logic [TICK_W-1:0]  timeout_ticks_q;
	logic [RETRY_W-1:0] max_timeouts_q;
	logic               fire;
	logic               out_free;
	burst_req_t         req;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
			max_timeouts_q  <= MAX_TIMEOUTS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[TICK_W-1:0];
				REG_MAX_TIMEOUTS:  max_timeouts_q  <= cfg_data[RETRY_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	lsh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.timeout_ticks (timeout_ticks_q),
		.max_timeouts  (max_timeouts_q),
		.out_free      (out_free),
		.fire          (fire),
		.req           (req)
	);

	lsh_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* hw/rtl/lsh_ctrl.sv */
// Handshake state, UA recognizer, timer and retry logic for one registered item.
module lsh_ctrl import lsh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  in_item_t            item_s1,
	input  logic [TICK_W-1:0]   timeout_ticks,
	input  logic [RETRY_W-1:0]  max_timeouts,
	input  logic                out_free,
	output logic                fire,
	output burst_req_t          req
);

	phase_t              phase_q, phase_d;
	frame_state_t        fs_q, fs_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [RETRY_W-1:0]  retry_q, retry_d;
	logic [TICK_W:0]     tick_next;
	logic [RETRY_W-1:0]  retry_inc;
	logic                ua_done;
	burst_t              burst;
	logic                frame_upd;
	frame_state_t        fs_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fs_q    <= FS_FLAG;
			tick_q  <= '0;
			retry_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			fs_q    <= fs_sel;
			tick_q  <= tick_d;
			retry_q <= retry_d;
		end
	end

	always_comb begin
		ua_done = 1'b0;
		unique case (fs_q)
			FS_FLAG: begin
				fs_d = (item_s1.rx_byte == FLAG_BYTE) ? FS_ADDR : FS_FLAG;
			end
			FS_ADDR: begin
				if (item_s1.rx_byte == ADDR_RX)        fs_d = FS_CTRL;
				else if (item_s1.rx_byte == FLAG_BYTE) fs_d = FS_ADDR;
				else                                   fs_d = FS_FLAG;
			end
			FS_CTRL: begin
				if (item_s1.rx_byte == CTRL_UA)        fs_d = FS_BCC;
				else if (item_s1.rx_byte == FLAG_BYTE) fs_d = FS_ADDR;
				else                                   fs_d = FS_FLAG;
			end
			FS_BCC: begin
				if (item_s1.rx_byte == (ADDR_RX ^ CTRL_UA)) fs_d = FS_END;
				else if (item_s1.rx_byte == FLAG_BYTE)      fs_d = FS_ADDR;
				else                                        fs_d = FS_FLAG;
			end
			FS_END: begin
				fs_d    = FS_FLAG;
				ua_done = (item_s1.rx_byte == FLAG_BYTE);
			end
			default: begin
				fs_d = FS_FLAG;
			end
		endcase
	end

	assign tick_next = {1'b0, tick_q} + {{TICK_W{1'b0}}, 1'b1};
	assign retry_inc = (retry_q < RETRY_SAT) ? retry_q + RETRY_W'(1) : retry_q;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		retry_d = retry_q;
		burst   = BURST_NONE;
		if (item_s1.action == ACT_START) begin
			phase_d = PH_WAIT;
			retry_d = '0;
			tick_d  = '0;
			burst   = BURST_SET;
		end else if (phase_q == PH_WAIT && item_s1.action == ACT_RX) begin
			if (ua_done) begin
				phase_d = PH_UP;
				tick_d  = '0;
				retry_d = '0;
				burst   = BURST_UP;
			end
		end else if (phase_q == PH_WAIT && item_s1.action == ACT_TICK) begin
			if (tick_next < {1'b0, timeout_ticks}) begin
				tick_d = tick_next[TICK_W-1:0];
			end else begin
				tick_d  = '0;
				retry_d = retry_inc;
				if (retry_inc >= max_timeouts) begin
					phase_d = PH_FAIL;
					burst   = BURST_FAIL;
				end else begin
					burst = BURST_SET;
				end
			end
		end
	end

	// frame_state moves only on a received byte while waiting; a SET burst resets it
	assign frame_upd = (phase_q == PH_WAIT) && (item_s1.action == ACT_RX);

	always_comb begin
		if (burst == BURST_SET) fs_sel = FS_FLAG;
		else if (frame_upd)     fs_sel = fs_d;
		else                    fs_sel = fs_q;
	end

	assign fire      = valid_s1 && (burst == BURST_NONE || out_free);
	assign req.valid = fire && (burst != BURST_NONE);
	assign req.kind  = burst;

endmodule

/* hw/rtl/lsh_out.sv */
// Result register that plays out one burst of result items.
module lsh_out import lsh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  burst_req_t req,
	output logic       out_free,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	logic              valid_q;
	burst_t            kind_q;
	logic [FIDX_W-1:0] idx_q;
	logic              last_item;

	assign last_item = (kind_q != BURST_SET) || (idx_q == FIDX_W'(FRAME_LEN - 1));
	assign out_free  = !valid_q || (out_ready && last_item);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q  <= BURST_NONE;
			idx_q   <= '0;
		end else if (req.valid) begin
			valid_q <= 1'b1;
			kind_q  <= req.kind;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last_item) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + FIDX_W'(1);
			end
		end
	end

	always_comb begin
		out_data.last = last_item;
		case (kind_q)
			BURST_SET: begin
				out_data.kind    = KIND_TX;
				out_data.tx_byte = set_byte(idx_q);
			end
			BURST_UP: begin
				out_data.kind    = KIND_UP;
				out_data.tx_byte = '0;
			end
			default: begin
				out_data.kind    = KIND_FAIL;
				out_data.tx_byte = '0;
			end
		endcase
	end

	assign out_valid = valid_q;

endmodule
